// File: sv/fbrm_pkg.sv
package fbrm_pkg;

    localparam int MAX_BUFFERS = 4;
    localparam int ADDR_REGS   = 4;
    // usable ring depth: smaller of the two limits, never below one
    localparam int RING_LIM_I  = (MAX_BUFFERS < ADDR_REGS) ? MAX_BUFFERS : ADDR_REGS;
    localparam int RING_LIM    = (RING_LIM_I < 1) ? 1 : RING_LIM_I;

    localparam int CNT_W  = 3;   // counts 0..4
    localparam int IDX_W  = 2;   // ring slot
    localparam int ADDR_W = 32;
    localparam int CIDX_W = 3;   // config register index
    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET_FREE   = 3'd0,
        KIND_PUT_READY  = 3'd1,
        KIND_GET_READY  = 3'd2,
        KIND_GET_LATEST = 3'd3,
        KIND_PUT_FREE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_RETRY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic [CIDX_W-1:0] REG_BUFFER_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ADDR_FIRST   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ADDR_LAST    = 3'd4;

    typedef logic [ADDR_REGS-1:0][ADDR_W-1:0] t_addr_array;

    // ring control from the register file to the core
    typedef struct packed {
        logic             init;       // buffer_count written this cycle
        logic [CNT_W-1:0] init_size;  // effective size being written
        logic [CNT_W-1:0] size;       // effective size in force
    } t_ring_ctl;

    function automatic logic [CNT_W-1:0] ring_size(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        n = count;
        if (n == '0) begin
            n = CNT_W'(1);
        end
        if (n > CNT_W'(RING_LIM)) begin
            n = CNT_W'(RING_LIM);
        end
        return n;
    endfunction

endpackage

// File: sv/frame_buffer_ring_manager.sv
// A command is registered in the input register, then in the result register, where
// its result shows with o_done high. Throughput: one command per cycle.
// Rate is set by the input register, the counter/index update logic and the
// result register. busy stays low; the receiver cannot stall results.
// Reset (synchronous, active low): buffer_count 1, addresses zero, one free buffer,
// nothing ready, both ring indices zero, no result pending.
module frame_buffer_ring_manager (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command beat
    input  logic                         start,
    output logic                         busy,
    input  logic [fbrm_pkg::KIND_W-1:0]  i_kind,
    input  logic                         i_should_wait,
    input  logic                         i_from_interrupt,
    // result beat
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [fbrm_pkg::ADDR_W-1:0]  o_buffer_address,
    output logic [fbrm_pkg::IDX_W-1:0]   o_slot_index,
    output logic [1:0]                   o_skipped_count,
    // configuration write beat
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fbrm_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [fbrm_pkg::ADDR_W-1:0]  i_cfg_data
);

    fbrm_pkg::t_ring_ctl   w_ctl;
    fbrm_pkg::t_addr_array w_addr;
    fbrm_pkg::t_status     w_status;

    // input register
    logic                  r_in_valid;
    fbrm_pkg::t_kind       r_in_kind;
    logic                  r_in_wait;

    // Every command completes in one pass, so nothing ever holds the port off.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // i_from_interrupt picks the ceiling put; as both counts saturate at the
    // ring size that put behaves like the plain one, so the bit is not used.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_kind <= fbrm_pkg::t_kind'(i_kind);
            r_in_wait <= i_should_wait;
        end
    end

    // register file: ring size and slot addresses; a size write re-initialises the ring
    fbrm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (w_ctl),
        .o_addr      (w_addr)
    );

    // counters, indices and the result register
    fbrm_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_in_valid),
        .i_kind           (r_in_kind),
        .i_wait           (r_in_wait),
        .i_ctl            (w_ctl),
        .i_addr           (w_addr),
        .o_done           (o_done),
        .o_status         (w_status),
        .o_buffer_address (o_buffer_address),
        .o_slot_index     (o_slot_index),
        .o_skipped_count  (o_skipped_count)
    );

    assign o_status = w_status;

endmodule

// File: sv/fbrm_cfg.sv
module fbrm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [fbrm_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [fbrm_pkg::ADDR_W-1:0]  i_cfg_data,
    output fbrm_pkg::t_ring_ctl          o_ctl,
    output fbrm_pkg::t_addr_array        o_addr
);

    logic [fbrm_pkg::CNT_W-1:0] r_size;
    fbrm_pkg::t_addr_array      r_addr;
    logic                       w_size_wr;

    assign w_size_wr = i_cfg_valid && (i_cfg_index == fbrm_pkg::REG_BUFFER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= fbrm_pkg::CNT_W'(1);
            r_addr <= '0;
        end else if (i_cfg_valid) begin
            if (w_size_wr) begin
                r_size <= fbrm_pkg::ring_size(i_cfg_data[fbrm_pkg::CNT_W-1:0]);
            end else if (i_cfg_index >= fbrm_pkg::REG_ADDR_FIRST &&
                         i_cfg_index <= fbrm_pkg::REG_ADDR_LAST) begin
                r_addr[fbrm_pkg::IDX_W'(i_cfg_index - fbrm_pkg::REG_ADDR_FIRST)] <= i_cfg_data;
            end
        end
    end

    assign o_ctl.init      = w_size_wr;
    assign o_ctl.init_size = fbrm_pkg::ring_size(i_cfg_data[fbrm_pkg::CNT_W-1:0]);
    assign o_ctl.size      = r_size;
    assign o_addr          = r_addr;

endmodule

// File: sv/fbrm_core.sv
module fbrm_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  fbrm_pkg::t_kind              i_kind,
    input  logic                         i_wait,
    input  fbrm_pkg::t_ring_ctl          i_ctl,
    input  fbrm_pkg::t_addr_array        i_addr,
    output logic                         o_done,
    output fbrm_pkg::t_status            o_status,
    output logic [fbrm_pkg::ADDR_W-1:0]  o_buffer_address,
    output logic [fbrm_pkg::IDX_W-1:0]   o_slot_index,
    output logic [1:0]                   o_skipped_count
);

    localparam int CW = fbrm_pkg::CNT_W;
    localparam int IW = fbrm_pkg::IDX_W;

    logic [CW-1:0] r_free, r_ready, n_free, n_ready;
    logic [IW-1:0] r_pi, r_ci, n_pi, n_ci;

    logic                 r_done;
    fbrm_pkg::t_status    r_status, n_status;
    logic [fbrm_pkg::ADDR_W-1:0] r_addr_out;
    logic [IW-1:0]        r_slot, n_slot;
    logic [1:0]           r_skip, n_skip;
    logic                 n_hand;

    logic [CW-1:0] w_n, w_pi, w_ci;
    logic [CW-1:0] w_last, w_ci_lat, w_free_lat;

    function automatic logic [IW-1:0] advance(input logic [CW-1:0] idx,
                                              input logic [CW-1:0] n);
        logic [CW-1:0] nx;
        nx = idx + CW'(1);
        return (nx >= n) ? '0 : nx[IW-1:0];
    endfunction

    always_comb begin
        w_n  = i_ctl.size;
        // indices stay below the ring size; guard anyway
        w_pi = ({1'b0, r_pi} >= w_n) ? '0 : {1'b0, r_pi};
        w_ci = ({1'b0, r_ci} >= w_n) ? '0 : {1'b0, r_ci};

        // get latest: jump straight to the newest ready slot
        w_last     = w_ci + r_ready - CW'(1);
        w_last     = (w_last >= w_n) ? w_last - w_n : w_last;
        w_ci_lat   = w_ci + r_ready;
        w_ci_lat   = (w_ci_lat >= w_n) ? w_ci_lat - w_n : w_ci_lat;
        w_free_lat = r_free + r_ready - CW'(1);
    end

    always_comb begin
        n_free   = r_free;
        n_ready  = r_ready;
        n_pi     = w_pi[IW-1:0];
        n_ci     = w_ci[IW-1:0];
        n_status = fbrm_pkg::ST_NONE;
        n_slot   = '0;
        n_skip   = '0;
        n_hand   = 1'b0;
        unique case (i_kind)
            fbrm_pkg::KIND_GET_FREE: begin
                if (r_free != '0) begin
                    n_free   = r_free - CW'(1);
                    n_slot   = w_pi[IW-1:0];
                    n_hand   = 1'b1;
                    n_pi     = advance(w_pi, w_n);
                    n_status = fbrm_pkg::ST_OK;
                end else begin
                    n_status = i_wait ? fbrm_pkg::ST_RETRY : fbrm_pkg::ST_NONE;
                end
            end
            fbrm_pkg::KIND_PUT_READY: begin
                if (r_ready >= w_n) begin
                    n_ready  = w_n;
                    n_status = fbrm_pkg::ST_OVERFLOW;
                end else begin
                    n_ready  = r_ready + CW'(1);
                    n_status = fbrm_pkg::ST_OK;
                end
            end
            fbrm_pkg::KIND_GET_READY: begin
                if (r_ready == '0) begin
                    n_status = fbrm_pkg::ST_RETRY;
                end else begin
                    n_ready  = r_ready - CW'(1);
                    n_slot   = w_ci[IW-1:0];
                    n_hand   = 1'b1;
                    n_ci     = advance(w_ci, w_n);
                    n_status = fbrm_pkg::ST_OK;
                end
            end
            fbrm_pkg::KIND_GET_LATEST: begin
                if (r_ready == '0) begin
                    n_status = fbrm_pkg::ST_RETRY;
                end else begin
                    // older ready beats go back to the free pool
                    n_ready  = '0;
                    n_slot   = w_last[IW-1:0];
                    n_hand   = 1'b1;
                    n_ci     = w_ci_lat[IW-1:0];
                    n_skip   = 2'(r_ready - CW'(1));
                    if (w_free_lat > w_n) begin
                        n_free   = w_n;
                        n_status = fbrm_pkg::ST_OVERFLOW;
                    end else begin
                        n_free   = w_free_lat;
                        n_status = fbrm_pkg::ST_OK;
                    end
                end
            end
            fbrm_pkg::KIND_PUT_FREE: begin
                if (r_free >= w_n) begin
                    n_free   = w_n;
                    n_status = fbrm_pkg::ST_OVERFLOW;
                end else begin
                    n_free   = r_free + CW'(1);
                    n_status = fbrm_pkg::ST_OK;
                end
            end
            default: begin
                n_status = fbrm_pkg::ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= CW'(1);
            r_ready <= '0;
            r_pi    <= '0;
            r_ci    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_valid;
            if (i_ctl.init) begin
                r_free  <= i_ctl.init_size;
                r_ready <= '0;
                r_pi    <= '0;
                r_ci    <= '0;
            end else if (i_valid) begin
                r_free  <= n_free;
                r_ready <= n_ready;
                r_pi    <= n_pi;
                r_ci    <= n_ci;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_status   <= n_status;
            r_slot     <= n_slot;
            r_skip     <= n_skip;
            r_addr_out <= n_hand ? i_addr[n_slot] : '0;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_buffer_address = r_addr_out;
    assign o_slot_index     = r_slot;
    assign o_skipped_count  = r_skip;

endmodule

// File: sv/fbrm_checker.sv
module fbrm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [1:0]                   o_status,
    input logic [fbrm_pkg::ADDR_W-1:0]  o_buffer_address,
    input logic [fbrm_pkg::IDX_W-1:0]   o_slot_index,
    input logic [1:0]                   o_skipped_count
);

    // each accepted command yields its result beat, through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result beat missing after command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result beat without command");

    // refusals hand out nothing
    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == fbrm_pkg::ST_NONE || o_status == fbrm_pkg::ST_RETRY))
        |-> (o_buffer_address == '0 && o_slot_index == '0 && o_skipped_count == '0))
        else $error("refused request handed out a buffer");

    a_skip_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_skipped_count != '0)
        |-> (o_status == fbrm_pkg::ST_OK || o_status == fbrm_pkg::ST_OVERFLOW))
        else $error("skipped buffers reported on a refused request");

endmodule

bind frame_buffer_ring_manager fbrm_checker u_fbrm_checker (.*);
